// ===== hdl/esc_lcd_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_lcd_pkg: shared types and constants for the escape sequence translator
// Character codes, LCD command bits, parser phases and digit helpers.
// ----------------------------------------------------------------------------
package esc_lcd_pkg;

	localparam logic [7:0] CHR_ESC   = 8'h1B;
	localparam logic [7:0] CHR_LBRK  = 8'h5B; // '['
	localparam logic [7:0] CHR_GT    = 8'h3E; // '>'
	localparam logic [7:0] CHR_FIVE  = 8'h35; // '5'
	localparam logic [7:0] CHR_LOW_L = 8'h6C; // 'l'
	localparam logic [7:0] CHR_LOW_H = 8'h68; // 'h'
	localparam logic [7:0] CHR_UP_J  = 8'h4A; // 'J'
	localparam logic [7:0] CHR_UP_H  = 8'h48; // 'H'
	localparam logic [7:0] CHR_SEMI  = 8'h3B; // ';'
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;

	localparam logic [7:0] CMD_DDADDR = 8'h80;
	localparam logic [7:0] CMD_DSP    = 8'h08;
	localparam logic [7:0] CMD_DSP_ON = 8'h04;
	localparam logic [7:0] CMD_CUR_ON = 8'h02;
	localparam logic [7:0] CMD_CLEAR  = 8'h01;

	localparam logic [7:0] CLEAR_COUNT = 8'd2;

	localparam int         BASE_W         = 7;
	localparam logic [6:0] LINE2_BASE_RST = 7'd64;

	typedef enum logic [5:0] {
		PH_BRACKET = 6'b000001,
		PH_OPEN    = 6'b000010,
		PH_GT      = 6'b000100,
		PH_GT5     = 6'b001000,
		PH_ROW     = 6'b010000,
		PH_COL     = 6'b100000
	} phase_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHR_ZERO) && (c <= CHR_NINE);
	endfunction

	// Decimal accumulate, modulo 256: acc*10 + digit.
	function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
		return {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + {4'd0, c[3:0]};
	endfunction

endpackage

// ===== hdl/esc_lcd_if.sv =====
// ----------------------------------------------------------------------------
// esc_lcd_if: request channels of the escape sequence translator
// Character input, LCD result output and register write channels.
// ----------------------------------------------------------------------------
interface esc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface esc_res_if;
	logic       valid;
	logic       ready;
	logic       write_valid;
	logic       reg_select;
	logic [7:0] lcd_byte;
	logic       seq_error;
	logic       in_sequence;
	modport source (output valid, output write_valid, output reg_select, output lcd_byte,
		output seq_error, output in_sequence, input ready);
	modport sink   (input valid, input write_valid, input reg_select, input lcd_byte,
		input seq_error, input in_sequence, output ready);
endinterface

interface esc_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/escape_sequence_lcd_translator.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_lcd_translator: ANSI escape subset to character-LCD writes
// A request is registered in stage 1, and its result is registered in stage 2.
// Throughput: one request per cycle while results are taken; the parser state loop needs no bubble.
// Reset: arst_n clears the pipeline valids and parser state, line2_base to 64.
// One result per character: data write, LCD command, error flag or nothing.
// ----------------------------------------------------------------------------
module escape_sequence_lcd_translator (
	input  logic          clk,
	input  logic          arst_n,
	esc_char_if.sink      chars,
	esc_res_if.source     results,
	esc_cfg_if.sink       cfg
);

	// Stage 1: registered input character.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Stage 2: registered result.
	logic       valid_s2;
	logic       wv_s2;
	logic       rs_s2;
	logic [7:0] byte_s2;
	logic       err_s2;
	logic       inseq_s2;

	// Parser state and the one register.
	logic                                seq_q;
	esc_lcd_pkg::phase_t                 phase_q;
	logic [7:0]                          row_q;
	logic [7:0]                          col_q;
	logic [esc_lcd_pkg::BASE_W-1:0]      line2_base_q;

	// Next state and result of the character in stage 1.
	logic                seq_nx;
	esc_lcd_pkg::phase_t phase_nx;
	logic [7:0]          row_nx;
	logic [7:0]          col_nx;
	logic                wv;
	logic                rs;
	logic [7:0]          lcd_b;
	logic                err;
	logic                bad;

	logic        s2_free;
	logic        s1_move;
	logic [7:0]  row_m1;
	logic [14:0] prod;
	logic [7:0]  addr;

	// Advance stage 2 when empty or taken; stage 1 moves into it then.
	assign s2_free     = !valid_s2 || results.ready;
	assign s1_move     = valid_s1 && s2_free;
	assign chars.ready = !valid_s1 || s2_free;
	assign cfg.ready   = 1'b1;

	// Cursor address: (col-1) + (row-1)*line2_base, low 8 bits only.
	assign row_m1 = row_q - 8'd1;
	assign prod   = 15'(row_m1) * 15'(line2_base_q);
	assign addr   = col_q - 8'd1 + prod[7:0];

	always_comb begin
		seq_nx   = seq_q;
		phase_nx = phase_q;
		row_nx   = row_q;
		col_nx   = col_q;
		wv       = 1'b0;
		rs       = 1'b0;
		lcd_b    = 8'h00;
		err      = 1'b0;
		bad      = 1'b0;
		if (char_s1 == esc_lcd_pkg::CHR_ESC) begin
			// Escape starts or restarts a sequence, silently.
			seq_nx   = 1'b1;
			phase_nx = esc_lcd_pkg::PH_BRACKET;
		end else if (!seq_q) begin
			// Plain text goes to the data register.
			wv    = 1'b1;
			rs    = 1'b1;
			lcd_b = char_s1;
		end else begin
			unique case (phase_q)
				esc_lcd_pkg::PH_BRACKET: begin
					if (char_s1 == esc_lcd_pkg::CHR_LBRK) phase_nx = esc_lcd_pkg::PH_OPEN;
					else bad = 1'b1;
				end
				esc_lcd_pkg::PH_OPEN: begin
					if (char_s1 == esc_lcd_pkg::CHR_GT) begin
						phase_nx = esc_lcd_pkg::PH_GT;
					end else if (esc_lcd_pkg::is_digit(char_s1)) begin
						row_nx   = {4'd0, char_s1[3:0]};
						phase_nx = esc_lcd_pkg::PH_ROW;
					end else begin
						bad = 1'b1;
					end
				end
				esc_lcd_pkg::PH_GT: begin
					if (char_s1 == esc_lcd_pkg::CHR_FIVE) phase_nx = esc_lcd_pkg::PH_GT5;
					else bad = 1'b1;
				end
				esc_lcd_pkg::PH_GT5: begin
					// Display on, with or without cursor.
					if (char_s1 == esc_lcd_pkg::CHR_LOW_L) begin
						wv     = 1'b1;
						lcd_b  = esc_lcd_pkg::CMD_DSP | esc_lcd_pkg::CMD_DSP_ON
							| esc_lcd_pkg::CMD_CUR_ON;
						seq_nx = 1'b0;
					end else if (char_s1 == esc_lcd_pkg::CHR_LOW_H) begin
						wv     = 1'b1;
						lcd_b  = esc_lcd_pkg::CMD_DSP | esc_lcd_pkg::CMD_DSP_ON;
						seq_nx = 1'b0;
					end else begin
						bad = 1'b1;
					end
				end
				esc_lcd_pkg::PH_ROW: begin
					if (esc_lcd_pkg::is_digit(char_s1)) begin
						row_nx = esc_lcd_pkg::acc_digit(row_q, char_s1);
					end else if (char_s1 == esc_lcd_pkg::CHR_UP_J) begin
						// Only a count of two clears the screen.
						if (row_q == esc_lcd_pkg::CLEAR_COUNT) begin
							wv     = 1'b1;
							lcd_b  = esc_lcd_pkg::CMD_CLEAR;
							seq_nx = 1'b0;
						end else begin
							bad = 1'b1;
						end
					end else if (char_s1 == esc_lcd_pkg::CHR_SEMI) begin
						phase_nx = esc_lcd_pkg::PH_COL;
						col_nx   = 8'd0;
					end else begin
						bad = 1'b1;
					end
				end
				esc_lcd_pkg::PH_COL: begin
					if (esc_lcd_pkg::is_digit(char_s1)) begin
						col_nx = esc_lcd_pkg::acc_digit(col_q, char_s1);
					end else if (char_s1 == esc_lcd_pkg::CHR_UP_H) begin
						wv     = 1'b1;
						lcd_b  = esc_lcd_pkg::CMD_DDADDR | addr;
						seq_nx = 1'b0;
					end else begin
						bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
			// Bad character: flag, drop the sequence, keep the phase.
			if (bad) begin
				err    = 1'b1;
				seq_nx = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			wv_s2    <= wv;
			rs_s2    <= rs;
			byte_s2  <= lcd_b;
			err_s2   <= err;
			inseq_s2 <= seq_nx;
		end
	end

	// Commit parser state as the character leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= 1'b0;
			phase_q <= esc_lcd_pkg::PH_BRACKET;
			row_q   <= 8'd0;
			col_q   <= 8'd0;
		end else if (s1_move) begin
			seq_q   <= seq_nx;
			phase_q <= phase_nx;
			row_q   <= row_nx;
			col_q   <= col_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line2_base_q <= esc_lcd_pkg::LINE2_BASE_RST;
		end else if (cfg.valid) begin
			line2_base_q <= cfg.data;
		end
	end

	assign results.valid       = valid_s2;
	assign results.write_valid = wv_s2;
	assign results.reg_select  = rs_s2;
	assign results.lcd_byte    = byte_s2;
	assign results.seq_error   = err_s2;
	assign results.in_sequence = inseq_s2;

endmodule
